FILE: rtl/button_press_classifier_queue_top_macros.svh
// Assertion macros for the button press classifier datapath.
`ifndef BUTTON_PRESS_CLASSIFIER_QUEUE_TOP_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_QUEUE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define BPQ_ASSERT(lbl, c_clk, c_rst, prop) \
  lbl: assert property (@(posedge c_clk) disable iff (c_rst) (prop)) \
    else $error("assertion failed");
`define BPQ_ASSERT_IMP(lbl, c_clk, c_rst, ante, cons) \
  lbl: assert property (@(posedge c_clk) disable iff (c_rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define BPQ_ASSERT(lbl, c_clk, c_rst, prop)
`define BPQ_ASSERT_IMP(lbl, c_clk, c_rst, ante, cons)
`endif

`endif

FILE: rtl/bpcq_pkg.sv
// Shared types and constants for the button press classifier.
package bpcq_pkg;

  localparam int MS_PER_SECOND = 1000;
  localparam int TIME_W        = 32;
  localparam int COUNT_W       = 16;
  localparam int STEP_W        = 8;
  localparam int LIMIT_W       = 16;
  localparam int HOLD_MS_W     = 18;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [COUNT_W-1:0]     HOLD_MAX        = '1;
  localparam logic [STEP_W-1:0]      STEP_RESET      = 8'd1;
  localparam logic [LIMIT_W-1:0]     LIMIT_RESET     = 16'd1001;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_STEP   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MOMENTARY   = 2'd1;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } ev_kind_t;

  typedef enum logic [1:0] {
    REP_PRESS     = 2'd0,
    REP_MOMENTARY = 2'd1,
    REP_LONG      = 2'd2
  } rep_t;

  typedef struct packed {
    logic enq;
    logic latch;
    logic pop;
    logic hold_emit;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_one;
    logic held;
    logic hold_due;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/button_press_classifier_queue_top.sv
// Top level of the button press classifier with event ring.
//
//  channel | signals                               | role
//  in      | in_valid/in_ready, kind, pin_level,   | pin changes and checks
//          | now_ms                                |
//  out     | out_valid/out_ready, report,          | classified results
//          | hold_count, last                      |
//  cfg     | cfg_valid/cfg_ready, cfg_index,       | register writes
//          | cfg_data                              |
//
// Pin changes can stream every cycle while the controller is idle (in_ready high).
// A check with queued events (up to QUEUE_DEPTH) moves the controller to DRAIN,
// which pops them all; with an empty ring and a held button it tests the hold step.
// A stalled output register holds the drain until out_ready.
// Synchronous reset; no clearing pass, the ring is usable right after reset.
// Config writes are always taken (cfg_ready stays high).
module button_press_classifier_queue_top
  import bpcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   kind,
  input  logic                   pin_level,
  input  logic [TIME_W-1:0]      now_ms,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             report,
  output logic [COUNT_W-1:0]     hold_count,
  output logic                   last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  bpcq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .status   (status),
    .cmd      (cmd)
  );

  bpcq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .pin_level  (pin_level),
    .now_ms     (now_ms),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .report     (report),
    .hold_count (hold_count),
    .last       (last)
  );

endmodule

FILE: rtl/bpcq_ctrl.sv
// Controller state machine: input handshake and drain/hold sequencing.
module bpcq_ctrl
  import bpcq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    kind,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DRAIN = 3'b010,
    ST_HOLD  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.enq       = accept && !kind;
    cmd.latch     = accept && kind;
    unique case (state)
      ST_IDLE: begin
        if (accept && kind) begin
          if (!status.count_zero) begin
            state_next = ST_DRAIN;
          end else if (status.held) begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_DRAIN: begin
        if (status.out_free) begin
          cmd.pop = 1'b1;
          if (status.count_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_HOLD: begin
        if (!status.hold_due) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.hold_emit = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/bpcq_datapath.sv
// Datapath: event ring, press/hold timing, config registers, result register.
`include "button_press_classifier_queue_top_macros.svh"
module bpcq_datapath
  import bpcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic                   pin_level,
  input  logic [TIME_W-1:0]      now_ms,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [1:0]             report,
  output logic [COUNT_W-1:0]     hold_count,
  output logic                   last
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  ev_kind_t           kinds [QUEUE_DEPTH];
  logic [TIME_W-1:0]  times [QUEUE_DEPTH];
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic               tail_valid;
  logic [CNT_W-1:0]   count;
  logic               held;
  logic [TIME_W-1:0]  press_time;
  logic [TIME_W-1:0]  step_time;
  logic [COUNT_W-1:0] hold_counter;
  logic [TIME_W-1:0]  chk_now;
  logic [HOLD_MS_W-1:0] hold_step_ms;
  logic [LIMIT_W-1:0] limit_ms;

  ev_kind_t           ev_new;
  ev_kind_t           head_kind;
  logic [TIME_W-1:0]  head_time;
  logic [PTR_W-1:0]   head_adv;
  logic [PTR_W-1:0]   tail_adv;
  logic               merge;
  logic [TIME_W-1:0]  press_gap;
  logic [TIME_W-1:0]  hold_gap;
  logic               momentary;
  logic [COUNT_W-1:0] hold_inc;
  logic               emit;
  rep_t               res_report;
  logic [COUNT_W-1:0] res_count;
  logic               res_last;

  assign ev_new    = pin_level ? EV_RELEASE : EV_PRESS;
  assign head_kind = kinds[head];
  assign head_time = times[head];
  assign head_adv  = (head == PTR_LAST) ? '0 : head + 1'b1;
  assign tail_adv  = (tail == PTR_LAST) ? '0 : tail + 1'b1;
  assign merge     = tail_valid && (kinds[tail] == ev_new);
  assign press_gap = head_time - press_time;
  assign hold_gap  = chk_now - step_time;
  assign momentary = press_gap < TIME_W'(limit_ms);
  assign hold_inc  = (hold_counter == HOLD_MAX) ? hold_counter : hold_counter + 1'b1;
  assign emit      = cmd.pop || cmd.hold_emit;

  assign status.count_zero = (count == '0);
  assign status.count_one  = (count == CNT_W'(1));
  assign status.held       = held;
  assign status.hold_due   = hold_gap >= TIME_W'(hold_step_ms);
  assign status.out_free   = !out_valid || out_ready;

  // config registers; step kept in ms
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_step_ms <= HOLD_MS_W'(STEP_RESET) * HOLD_MS_W'(MS_PER_SECOND);
      limit_ms     <= LIMIT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_HOLD_STEP) begin
        hold_step_ms <= HOLD_MS_W'(cfg_data[STEP_W-1:0]) * HOLD_MS_W'(MS_PER_SECOND);
      end else if (cfg_index == CFG_MOMENTARY) begin
        limit_ms <= cfg_data[LIMIT_W-1:0];
      end
    end
  end

  // ring control
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= PTR_LAST;
      tail_valid <= 1'b0;
      count      <= '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        kinds[i] <= EV_NONE;
      end
    end else if (cmd.enq) begin
      if (!merge && (count != CNT_FULL)) begin
        tail        <= tail_adv;
        tail_valid  <= 1'b1;
        kinds[tail_adv] <= ev_new;
        count       <= count + 1'b1;
      end
    end else if (cmd.pop) begin
      kinds[head] <= EV_NONE;
      head        <= head_adv;
      count       <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      if (merge) begin
        times[tail] <= now_ms;
      end else if (count != CNT_FULL) begin
        times[tail_adv] <= now_ms;
      end
    end
    if (cmd.latch) begin
      chk_now <= now_ms;
    end
  end

  // press and hold tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      held         <= 1'b0;
      press_time   <= '0;
      step_time    <= '0;
      hold_counter <= '0;
    end else if (cmd.pop) begin
      if (head_kind == EV_PRESS) begin
        held         <= 1'b1;
        press_time   <= head_time;
        step_time    <= head_time;
        hold_counter <= '0;
      end else begin
        held <= 1'b0;
      end
    end else if (cmd.hold_emit) begin
      hold_counter <= hold_inc;
      step_time    <= chk_now;
    end
  end

  always_comb begin
    res_report = REP_PRESS;
    res_count  = '0;
    res_last   = 1'b1;
    if (cmd.hold_emit) begin
      res_count = hold_inc;
    end else begin
      res_last = status.count_one;
      if (head_kind != EV_PRESS) begin
        if (momentary) begin
          res_report = REP_MOMENTARY;
        end else begin
          res_report = REP_LONG;
          res_count  = hold_counter;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      report     <= res_report;
      hold_count <= res_count;
      last       <= res_last;
    end
  end

  `BPQ_ASSERT(a_count_bound, clk, rst, count <= CNT_FULL)
  `BPQ_ASSERT(a_enq_pop_excl, clk, rst, !(cmd.enq && cmd.pop))
  `BPQ_ASSERT_IMP(a_emit_free, clk, rst, emit, !out_valid || out_ready)
  `BPQ_ASSERT_IMP(a_head_filled, clk, rst, count != '0, kinds[head] != EV_NONE)

endmodule

FILE: tb/button_press_classifier_queue_top_test.sv
// Self-checking testbench for the button press classifier: queued stimulus, predictor, scoreboard.
`timescale 1ns / 100ps

module button_press_classifier_queue_top_test
  import bpcq_pkg::*;
;

  localparam int QDEPTH       = 4;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int STEP_CHECKS  = 12;

  localparam logic KIND_PIN     = 1'b0;
  localparam logic KIND_CHECK   = 1'b1;
  localparam logic PIN_PRESSED  = 1'b0;
  localparam logic PIN_RELEASED = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct {
    logic              k;
    logic              lvl;
    logic [TIME_W-1:0] t;
  } button_input_t;

  typedef struct {
    rep_t               rep;
    logic [COUNT_W-1:0] cnt;
    logic               fin;
  } button_report_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   kind = KIND_PIN;
  logic                   pin_level = PIN_RELEASED;
  logic [TIME_W-1:0]      now_ms = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             out_report;
  logic [COUNT_W-1:0]     out_count;
  logic                   out_last;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_HOLD_STEP;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  button_input_t  input_backlog[$];
  button_report_t expected_reports[$];

  // predictor state
  ev_kind_t           ring_kind[QDEPTH];
  logic [TIME_W-1:0]  ring_time[QDEPTH];
  int                 head_ptr = 0;
  int                 tail_ptr = QDEPTH - 1;
  bit                 tail_used = 0;
  int                 ring_fill = 0;
  bit                 held = 0;
  logic [TIME_W-1:0]  press_time = '0;
  logic [TIME_W-1:0]  step_time = '0;
  logic [COUNT_W-1:0] hold_cnt = '0;
  logic [STEP_W-1:0]  hold_step = STEP_RESET;
  logic [LIMIT_W-1:0] mom_limit = LIMIT_RESET;

  int                items_queued = 0;
  int                items_taken = 0;
  int                n_results = 0;
  int                n_errors = 0;
  int                n_settings = 0;
  int                cycle_count = 0;
  int                gap_left = 0;
  int                burst_left = 4;
  int                stall_mode = 0;
  int                stall_timer = 1;
  bit                quiet = 0;
  logic [TIME_W-1:0] clock_ms = 32'hFFF0_0000;

  button_press_classifier_queue_top #(.QUEUE_DEPTH(QDEPTH)) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .pin_level  (pin_level),
    .now_ms     (now_ms),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .report     (out_report),
    .hold_count (out_count),
    .last       (out_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < QDEPTH; i++) begin
      ring_kind[i] = EV_NONE;
      ring_time[i] = '0;
    end
  end

  task automatic classify_input(input logic k, input logic lvl, input logic [TIME_W-1:0] t);
    ev_kind_t          ev;
    ev_kind_t          ek;
    logic [TIME_W-1:0] et;
    logic [TIME_W-1:0] span;
    button_report_t    r;
    if (k == KIND_PIN) begin
      ev = (lvl == PIN_RELEASED) ? EV_RELEASE : EV_PRESS;
      if (tail_used && ring_kind[tail_ptr] == ev) begin
        ring_time[tail_ptr] = t;
      end else if (ring_fill < QDEPTH) begin
        tail_ptr = (tail_ptr + 1) % QDEPTH;
        tail_used = 1;
        ring_time[tail_ptr] = t;
        ring_kind[tail_ptr] = ev;
        ring_fill++;
      end
    end else if (ring_fill > 0) begin
      while (ring_fill > 0) begin
        ek = ring_kind[head_ptr];
        et = ring_time[head_ptr];
        ring_kind[head_ptr] = EV_NONE;
        head_ptr = (head_ptr + 1) % QDEPTH;
        ring_fill--;
        r.fin = (ring_fill == 0);
        if (ek == EV_PRESS) begin
          hold_cnt = '0;
          step_time = et;
          press_time = et;
          held = 1;
          r.rep = REP_PRESS;
          r.cnt = '0;
        end else begin
          held = 0;
          span = et - press_time;
          if (span < TIME_W'(mom_limit)) begin
            r.rep = REP_MOMENTARY;
            r.cnt = '0;
          end else begin
            r.rep = REP_LONG;
            r.cnt = hold_cnt;
          end
        end
        expected_reports.push_back(r);
      end
    end else if (held) begin
      span = t - step_time;
      if (span / TIME_W'(MS_PER_SECOND) >= TIME_W'(hold_step)) begin
        if (hold_cnt != HOLD_MAX) hold_cnt++;
        step_time = t;
        r.rep = REP_PRESS;
        r.cnt = hold_cnt;
        r.fin = 1'b1;
        expected_reports.push_back(r);
      end
    end
  endtask

  // sender: bursts of transfers separated by random gaps
  always @(posedge clk) begin : drive_inputs
    button_input_t nxt;
    if (!rst) begin
      if (in_valid && in_ready) begin
        classify_input(kind, pin_level, now_ms);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 && !quiet) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (input_backlog.size() > 0) begin
          nxt = input_backlog.pop_front();
          kind <= nxt.k;
          pin_level <= nxt.lvl;
          now_ms <= nxt.t;
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                   : $urandom_range(0, 4);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: compare each result transfer, stall on a changing pattern
  always @(posedge clk) begin : check_outputs
    button_report_t want;
    logic           rdy;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (expected_reports.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result: report %0d hold_count %0d last %0b",
                 $time, out_report, out_count, out_last);
      end else begin
        want = expected_reports.pop_front();
        if (out_report !== want.rep) begin
          n_errors++;
          $display("%0t: report: expected %0d, actual %0d", $time, want.rep, out_report);
        end
        if (out_count !== want.cnt) begin
          n_errors++;
          $display("%0t: hold_count: expected %0d, actual %0d", $time, want.cnt, out_count);
        end
        if (out_last !== want.fin) begin
          n_errors++;
          $display("%0t: last: expected %0b, actual %0b", $time, want.fin, out_last);
        end
      end
    end
    stall_timer--;
    if (stall_timer <= 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_timer = $urandom_range(16, 96);
    end
    case (stall_mode)
      0: rdy = 1'b1;
      1: rdy = 1'($urandom_range(0, 1));
      2: rdy = (stall_timer % 3 == 0);
      default: rdy = ($urandom_range(0, 7) == 0);
    endcase
    out_ready <= rdy || quiet;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, expected_reports.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_item(input logic k, input logic lvl, input logic [TIME_W-1:0] t);
    button_input_t it;
    it.k = k;
    it.lvl = lvl;
    it.t = t;
    input_backlog.push_back(it);
    items_queued++;
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_HOLD_STEP) hold_step = data[STEP_W-1:0];
    else if (idx == CFG_MOMENTARY) mom_limit = data[LIMIT_W-1:0];
  endtask

  task automatic set_registers(input logic [STEP_W-1:0] step, input logic [LIMIT_W-1:0] lim);
    wait_idle();
    write_reg(CFG_HOLD_STEP, {8'($urandom), step});
    if ($urandom_range(0, 1))
      write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
    write_reg(CFG_MOMENTARY, lim);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [TIME_W-1:0] pick_gap();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 20);
      1, 2: return $urandom_range(0, 1500);
      3: return TIME_W'(mom_limit) - 1 + $urandom_range(0, 2);
      4: return TIME_W'(hold_step) * 1000 - 1 + $urandom_range(0, 2);
      5: return TIME_W'(hold_step) * 1000 + $urandom_range(0, 1500);
      6: return $urandom;
      default: return $urandom_range(0, 5000);
    endcase
  endfunction

  task automatic random_traffic(input int n);
    int start;
    int k;
    start = items_queued;
    while (items_queued - start < n) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          k = $urandom_range(1, 6);
          repeat (k) begin
            clock_ms += pick_gap();
            push_item(KIND_PIN, 1'($urandom_range(0, 1)), clock_ms);
          end
          clock_ms += pick_gap();
          push_item(KIND_CHECK, 1'($urandom_range(0, 1)), clock_ms);
        end
        2:
          push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
        default: begin
          clock_ms += pick_gap();
          push_item(KIND_PIN, PIN_PRESSED, clock_ms);
          if ($urandom_range(0, 3) == 0) begin
            clock_ms += $urandom_range(0, 30);
            push_item(KIND_PIN, PIN_PRESSED, clock_ms);
          end
          k = $urandom_range(0, 4);
          repeat (k) begin
            clock_ms += pick_gap();
            push_item(KIND_CHECK, 1'($urandom_range(0, 1)), clock_ms);
          end
          clock_ms += pick_gap();
          push_item(KIND_PIN, PIN_RELEASED, clock_ms);
          if ($urandom_range(0, 1)) begin
            clock_ms += pick_gap();
            push_item(KIND_CHECK, 1'($urandom_range(0, 1)), clock_ms);
          end
        end
      endcase
    end
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0] base;
    base = 32'hFFFF_FC00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values
    push_item(KIND_CHECK, PIN_RELEASED, base);
    push_item(KIND_PIN, PIN_PRESSED, base);
    push_item(KIND_PIN, PIN_PRESSED, base + 5);
    push_item(KIND_PIN, PIN_RELEASED, base + 300);
    push_item(KIND_CHECK, PIN_PRESSED, base + 301);
    push_item(KIND_PIN, PIN_PRESSED, base + 1000);
    push_item(KIND_CHECK, PIN_RELEASED, base + 1001);
    push_item(KIND_CHECK, PIN_PRESSED, base + 1999);
    push_item(KIND_CHECK, PIN_PRESSED, base + 2000);
    push_item(KIND_CHECK, PIN_PRESSED, base + 3500);
    push_item(KIND_PIN, PIN_RELEASED, base + 4000);
    push_item(KIND_CHECK, PIN_PRESSED, base + 4001);
    // fill the ring, then overflow and merge into a full ring
    push_item(KIND_PIN, PIN_PRESSED, 32'h0000_1000);
    push_item(KIND_PIN, PIN_RELEASED, 32'h0000_1000 + 1000);
    push_item(KIND_PIN, PIN_PRESSED, 32'h0000_2000);
    push_item(KIND_PIN, PIN_RELEASED, 32'h0000_2000 + 1001);
    push_item(KIND_PIN, PIN_PRESSED, 32'h0000_3000);
    push_item(KIND_PIN, PIN_RELEASED, 32'h0000_4000);
    push_item(KIND_CHECK, PIN_RELEASED, 32'hFFFF_FFFF);
    // same type as the drained tail is queued again
    push_item(KIND_PIN, PIN_RELEASED, 32'h0000_5000);
    push_item(KIND_CHECK, PIN_PRESSED, 32'h0000_0000);
    push_item(KIND_PIN, PIN_PRESSED, 32'hFFFF_FFFF);
    push_item(KIND_CHECK, PIN_RELEASED, 32'hFFFF_FFFF);
    push_item(KIND_CHECK, PIN_PRESSED, 32'h0000_03E7);
    push_item(KIND_PIN, PIN_RELEASED, 32'h0000_0000);
    push_item(KIND_CHECK, PIN_RELEASED, 32'h0000_0001);

    set_registers(8'd0, 16'd1);
    random_traffic(50);
    set_registers(8'd255, 16'd65535);
    random_traffic(50);
    set_registers(STEP_RESET, LIMIT_RESET);
    random_traffic(50);
    repeat (3) begin
      set_registers($urandom_range(0, 1) ? 8'($urandom_range(0, 5)) : 8'($urandom),
                    16'($urandom_range(1, 65535)));
      random_traffic(50);
    end

    // zero step: every check while held steps the counter
    set_registers(8'd0, 16'($urandom_range(1, 65535)));
    quiet = 1;
    push_item(KIND_PIN, PIN_PRESSED, clock_ms);
    push_item(KIND_CHECK, PIN_PRESSED, clock_ms);
    repeat (STEP_CHECKS) push_item(KIND_CHECK, 1'($urandom_range(0, 1)), $urandom);
    push_item(KIND_PIN, PIN_RELEASED, clock_ms + 32'h4000_0000);
    push_item(KIND_CHECK, PIN_RELEASED, clock_ms + 32'h4000_0001);
    wait_idle();
    quiet = 0;

    if (expected_reports.size() != 0) begin
      n_errors++;
      $display("%0t: %0d expected results never arrived", $time, expected_reports.size());
    end
    $display("Run covered %0d input transfers and %0d result transfers over %0d settings,",
             items_taken, n_results, n_settings);
    $display("including ring overflow, merges, momentary and long releases, zero-step holds.");
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bpcq_pkg.sv
rtl/bpcq_ctrl.sv
rtl/bpcq_datapath.sv
rtl/button_press_classifier_queue_top.sv
tb/button_press_classifier_queue_top_test.sv
